FILE: src/mfbr_pkg.sv
// Shared types, opcodes, status codes and sizing constants of the MSB-first bit reader.
package mfbr_pkg;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int MAX_FIELD_BITS  = 31;

	localparam int NUM_BANKS  = 8;
	localparam int BANK_SEL_W = 3;
	localparam int WIN_BYTES  = 5;
	localparam int WIN_BITS   = WIN_BYTES * 8;
	localparam int CNT_W      = 5;
	localparam int LEFT_W     = 16;
	localparam int FIELD_W    = 31;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PUSH  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [7:0]       byte_in;
		logic [CNT_W-1:0] bit_count;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field_value;
		logic [CNT_W-1:0]   bits_returned;
		logic [LEFT_W-1:0]  bits_left;
		logic [1:0]         status;
	} out_t;

endpackage

FILE: src/mfbr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module mfbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/mfbr_bank_store.sv
// Byte store as eight interleaved RAM banks, giving a five-byte read window per cycle.
module mfbr_bank_store #(
	parameter int STORE_BYTES = mfbr_pkg::STORE_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [$clog2(STORE_BYTES+1)-1:0]      rd_idx,
	input  logic                                  wr_en,
	input  logic [$clog2(STORE_BYTES+1)-1:0]      wr_idx,
	input  logic [7:0]                            wr_data,
	output logic [mfbr_pkg::WIN_BITS-1:0]         window
);

	import mfbr_pkg::*;

	localparam int ROWS  = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [31:0]           rd_idx32;
	logic [31:0]           wr_idx32;
	logic [31:0]           rd_row_base;
	logic [BANK_SEL_W-1:0] rd_lo;
	logic [BANK_SEL_W-1:0] wr_bank;
	logic [ROW_W-1:0]      wr_row;
	logic [BANK_SEL_W-1:0] rd_lo_q;
	logic [7:0]            bank_data [NUM_BANKS];

	assign rd_idx32    = 32'(rd_idx);
	assign wr_idx32    = 32'(wr_idx);
	assign rd_row_base = rd_idx32 >> BANK_SEL_W;
	assign rd_lo       = rd_idx32[BANK_SEL_W-1:0];
	assign wr_bank     = wr_idx32[BANK_SEL_W-1:0];
	assign wr_row      = ROW_W'(wr_idx32 >> BANK_SEL_W);

	// Banks below the first byte's bank wrap into the next row.
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [ROW_W-1:0] rd_row;

		assign rd_row = ROW_W'(rd_row_base + ((BANK_SEL_W'(b) < rd_lo) ? 32'd1 : 32'd0));

		mfbr_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (wr_en && (wr_bank == BANK_SEL_W'(b))),
			.waddr(wr_row),
			.wdata(wr_data),
			.re   (rd_en),
			.raddr(rd_row),
			.rdata(bank_data[b])
		);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_lo_q <= rd_lo;
		end
	end

	// Rotate bank outputs so the first byte lands at the top of the window.
	always_comb begin
		for (int j = 0; j < WIN_BYTES; j++) begin
			window[WIN_BITS-1-8*j -: 8] = bank_data[BANK_SEL_W'(32'(rd_lo_q) + j)];
		end
	end

endmodule

FILE: src/mfbr_extract.sv
// Field extraction: shift the byte window and mask the requested bits, right-aligned.
module mfbr_extract (
	input  logic [mfbr_pkg::WIN_BITS-1:0] window,
	input  logic [2:0]                    bit_off,
	input  logic [mfbr_pkg::CNT_W-1:0]    count,
	output logic [mfbr_pkg::FIELD_W-1:0]  value
);

	import mfbr_pkg::*;

	logic [5:0]          shamt;
	logic [WIN_BITS-1:0] shifted;
	logic [WIN_BITS-1:0] mask;

	always_comb begin
		shamt   = 6'(WIN_BITS) - 6'(bit_off) - 6'(count);
		shifted = window >> shamt;
		mask    = (WIN_BITS'(1) << count) - WIN_BITS'(1);
		value   = FIELD_W'(shifted & mask);
	end

endmodule

FILE: src/msb_first_bit_reader.sv
// Top level of the MSB-first bit reader: control, state registers and result pipeline.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | in        | in_valid / in_ready | in_data  : opcode, byte_in, bit_count
//  out     | out       | out_valid/out_ready | out_data : field_value, bits_returned,
//          |           |                     |            bits_left, status
//
// One item per cycle sustained while out_ready stays high. The banked store is read
// at the transfer edge into the window stage, and the shift-and-mask result register
// loads from the window stage once the result register is free to take it. The
// store is eight interleaved RAM banks so a read's five-byte window takes one access.
// Reset clears fill, bit position and valid flags; bytes are never read unpushed.
// A stalled output holds the result register, then the window stage, then in_ready.
module msb_first_bit_reader #(
	parameter int STORE_BYTES = mfbr_pkg::STORE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mfbr_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mfbr_pkg::out_t out_data
);

	import mfbr_pkg::*;

	localparam int FILL_W = $clog2(STORE_BYTES + 1);
	localparam int POS_W  = FILL_W + 3;

	// architectural state
	logic [FILL_W-1:0] fill_q;
	logic [POS_W-1:0]  pos_q;

	// next state and per-item decode
	logic              accept;
	logic [FILL_W-1:0] fill_d;
	logic [POS_W-1:0]  pos_d;
	logic [POS_W-1:0]  rem;
	logic [POS_W-1:0]  rem_d;
	logic [31:0]       rem_d32;
	logic [CNT_W-1:0]  cnt_clamp;
	logic [CNT_W-1:0]  got;
	logic [1:0]        status;
	logic              full;
	logic              rd_en;
	logic              wr_en;

	// window stage
	logic              valid_s1;
	logic [2:0]        off_s1;
	logic [CNT_W-1:0]  got_s1;
	logic [LEFT_W-1:0] left_s1;
	logic [1:0]        status_s1;
	logic [WIN_BITS-1:0] window;
	logic [FIELD_W-1:0]  value;

	// result register
	logic              valid_s2;
	out_t              result_s2;
	logic              take_s2;

	assign take_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || take_s2;
	assign accept   = in_valid && in_ready;

	assign rem  = {fill_q, 3'b000} - pos_q;
	assign full = (32'(fill_q) >= 32'(STORE_BYTES));

	always_comb begin
		cnt_clamp = (32'(in_data.bit_count) > 32'(MAX_FIELD_BITS))
			? CNT_W'(MAX_FIELD_BITS) : in_data.bit_count;
		fill_d = fill_q;
		pos_d  = pos_q;
		got    = '0;
		status = ST_OK;
		rd_en  = 1'b0;
		wr_en  = 1'b0;
		case (in_data.opcode)
			OP_START: begin
				fill_d = '0;
				pos_d  = '0;
			end
			OP_PUSH: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					fill_d = fill_q + FILL_W'(1);
					wr_en  = accept;
				end
			end
			OP_READ: begin
				if (POS_W'(cnt_clamp) > rem) begin
					status = ST_SHORT;
				end else begin
					pos_d = pos_q + POS_W'(cnt_clamp);
					got   = cnt_clamp;
					rd_en = accept;
				end
			end
			default: begin
				// unused opcode: leave state alone
			end
		endcase
		rem_d   = {fill_d, 3'b000} - pos_d;
		rem_d32 = 32'(rem_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
			pos_q  <= pos_d;
		end
	end

	// The read window starts at the byte holding the current bit position.
	mfbr_bank_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_idx (pos_q[POS_W-1:3]),
		.wr_en  (wr_en),
		.wr_idx (fill_q),
		.wr_data(in_data.byte_in),
		.window (window)
	);

	// Window stage: advance on transfer, drop once passed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_s1    <= pos_q[2:0];
			got_s1    <= got;
			left_s1   <= rem_d32[LEFT_W-1:0];
			status_s1 <= status;
		end
	end

	mfbr_extract u_extract (
		.window (window),
		.bit_off(off_s1),
		.count  (got_s1),
		.value  (value)
	);

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && take_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && take_s2) begin
			result_s2.field_value   <= value;
			result_s2.bits_returned <= got_s1;
			result_s2.bits_left     <= left_s1;
			result_s2.status        <= status_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Read position never passes the end of the pushed bytes.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= {fill_q, 3'b000})
		else $error("read position beyond filled bytes");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(STORE_BYTES))
		else $error("fill count beyond store size");

	// A full pipeline with a stalled consumer takes no new item.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline is blocked");

	// A failed read or refused push returns no bits, as does any non-read.
	a_no_bits_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_s2.status == ST_SHORT || result_s2.status == ST_FULL))
			|-> (result_s2.bits_returned == '0 && result_s2.field_value == '0))
		else $error("bits returned on failed item");

	// A pushed byte lands in the store only when there is room, and advances the fill count.
	a_push_grows_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("fill count did not advance on push");

endmodule
